// ===== sv/trle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package trle_pkg;

    localparam int MAX_RUN      = 128;
    localparam int MAX_CHANNELS = 4;
    localparam int RUN_W        = 8;
    localparam int CNT_W        = 3;
    localparam int OQ_DEPTH     = 4;
    localparam int OQ_PTR_W     = 2;
    localparam int OQ_CNT_W     = 3;

    localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;
    localparam logic [7:0] HDR_RUN_FLAG   = 8'h80;

    typedef struct packed {
        logic       final_pixel;
        logic [7:0] pix_byte3;
        logic [7:0] pix_byte2;
        logic [7:0] pix_byte1;
        logic [7:0] pix_byte0;
    } in_beat_t;

    typedef struct packed {
        logic       image_done;
        logic [7:0] out_byte3;
        logic [7:0] out_byte2;
        logic [7:0] out_byte1;
        logic [7:0] out_byte0;
        logic [7:0] packet_header;
    } out_beat_t;

    typedef struct packed {
        logic       eq;
        logic [7:0] px_byte;
        logic [7:0] held_byte;
    } lane_res_t;

    typedef struct packed {
        logic      valid0;
        logic      valid1;
        out_beat_t beat0;
        out_beat_t beat1;
    } pkt_pair_t;

    function automatic logic [7:0] pkt_header(input logic [RUN_W-1:0] run_len);
        logic [RUN_W-1:0] cm1;
        begin
            cm1 = run_len - RUN_W'(1);
            if (run_len > RUN_W'(1)) begin
                pkt_header = HDR_RUN_FLAG | {1'b0, cm1[6:0] & HDR_COUNT_MASK};
            end else begin
                pkt_header = 8'h00;
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/trle_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trle_lane (
    input  wire logic              active,
    input  wire logic [7:0]        px_byte,
    input  wire logic [7:0]        held_byte,
    output trle_pkg::lane_res_t    res
);
    import trle_pkg::*;

    logic [7:0] px_m;
    logic [7:0] held_m;

    assign px_m   = active ? px_byte : 8'h00;
    assign held_m = active ? held_byte : 8'h00;

    assign res.eq        = (px_m == held_m);
    assign res.px_byte   = px_m;
    assign res.held_byte = held_m;

endmodule

`default_nettype wire

// ===== sv/trle_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trle_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire trle_pkg::pkt_pair_t push,
    output logic                     room2,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output trle_pkg::out_beat_t      m_data
);
    import trle_pkg::*;

    out_beat_t               mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]     count_reg, count_next;
    logic                    pop;
    logic [OQ_CNT_W-1:0]     n_push;
    logic [OQ_PTR_W-1:0]     wr_ptr_1;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = mem_reg[rd_ptr_reg];
    assign room2    = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign wr_ptr_1 = wr_ptr_reg + OQ_PTR_W'(1);

    always_comb begin
        n_push      = OQ_CNT_W'(push.valid0) + OQ_CNT_W'(push.valid1);
        wr_ptr_next = wr_ptr_reg + n_push[OQ_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
        count_next  = count_reg + n_push - OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            mem_reg[wr_ptr_reg] <= push.beat0;
        end
        if (push.valid1) begin
            mem_reg[wr_ptr_1] <= push.beat1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/targa_rle_pixel_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Handshake      Beat
// input     s_valid s_ready s_data       valid/ready    one pixel
// output    m_valid m_ready m_data       valid/ready    one packet
// config    cfg_wr_en cfg_wr_data        write enable   channel_count
//
// One pixel is taken per cycle; its packets are written to a four-entry output
// queue in the same cycle and leave one beat per cycle while m_ready is high.
// s_ready drops only while the queue has fewer than two free entries.
// A pixel that closes a run and is final yields two beats in one cycle.
// aresetn (synchronous) empties the run, the queue, and sets channel_count to 4.

module targa_rle_pixel_encoder_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire trle_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output trle_pkg::out_beat_t      m_data
);
    import trle_pkg::*;

    logic [CNT_W-1:0]  chan_cnt_reg;
    logic [7:0]        held_reg [MAX_CHANNELS];
    logic [7:0]        held_next [MAX_CHANNELS];
    logic [RUN_W-1:0]  run_reg, run_next;

    logic [CNT_W-1:0]        eff_cnt;
    logic [MAX_CHANNELS-1:0] active;
    logic [7:0]              px_in [MAX_CHANNELS];
    lane_res_t               lane_res [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] lane_eq;

    logic              accept;
    logic              close_run;
    logic [RUN_W-1:0]  run_mid;
    logic [RUN_W-1:0]  run_new;
    logic [7:0]        mid_byte [MAX_CHANNELS];
    out_beat_t         pkt_close;
    out_beat_t         pkt_flush;
    pkt_pair_t         push;
    logic              room2;

    assign px_in[0] = s_data.pix_byte0;
    assign px_in[1] = s_data.pix_byte1;
    assign px_in[2] = s_data.pix_byte2;
    assign px_in[3] = s_data.pix_byte3;

    always_comb begin
        if (chan_cnt_reg == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (chan_cnt_reg > CNT_W'(MAX_CHANNELS)) begin
            eff_cnt = CNT_W'(MAX_CHANNELS);
        end else begin
            eff_cnt = chan_cnt_reg;
        end
    end

    genvar c;
    generate
        for (c = 0; c < MAX_CHANNELS; c++) begin : g_lane
            assign active[c] = (CNT_W'(c) < eff_cnt);
            trle_lane u_lane (
                .active    (active[c]),
                .px_byte   (px_in[c]),
                .held_byte (held_reg[c]),
                .res       (lane_res[c])
            );
            assign lane_eq[c]  = lane_res[c].eq;
            assign mid_byte[c] = (run_mid == '0) ? lane_res[c].px_byte : held_reg[c];
        end
    endgenerate

    assign accept  = s_valid && s_ready;
    assign s_ready = room2;

    always_comb begin
        close_run = (run_reg != '0) &&
                    ((~&lane_eq) || (run_reg >= RUN_W'(MAX_RUN)));
        run_mid   = close_run ? '0 : run_reg;
        run_new   = run_mid + RUN_W'(1);

        pkt_close.packet_header = pkt_header(run_reg);
        pkt_close.out_byte0     = lane_res[0].held_byte;
        pkt_close.out_byte1     = lane_res[1].held_byte;
        pkt_close.out_byte2     = lane_res[2].held_byte;
        pkt_close.out_byte3     = lane_res[3].held_byte;
        pkt_close.image_done    = 1'b0;

        pkt_flush.packet_header = pkt_header(run_new);
        pkt_flush.out_byte0     = active[0] ? mid_byte[0] : 8'h00;
        pkt_flush.out_byte1     = active[1] ? mid_byte[1] : 8'h00;
        pkt_flush.out_byte2     = active[2] ? mid_byte[2] : 8'h00;
        pkt_flush.out_byte3     = active[3] ? mid_byte[3] : 8'h00;
        pkt_flush.image_done    = 1'b1;

        push.valid0 = accept && (close_run || s_data.final_pixel);
        push.valid1 = accept && close_run && s_data.final_pixel;
        push.beat0  = close_run ? pkt_close : pkt_flush;
        push.beat1  = pkt_flush;

        run_next = run_reg;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            held_next[i] = held_reg[i];
        end
        if (accept) begin
            if (s_data.final_pixel) begin
                run_next = '0;
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    held_next[i] = 8'h00;
                end
            end else begin
                run_next = run_new;
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    held_next[i] = mid_byte[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg <= CNT_W'(MAX_CHANNELS);
            run_reg      <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                held_reg[i] <= 8'h00;
            end
        end else begin
            if (cfg_wr_en) begin
                chan_cnt_reg <= cfg_wr_data;
            end
            run_reg <= run_next;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    trle_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RUN_W'(MAX_RUN))
        else $error("run length above maximum");

    a_final_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_pixel |=> run_reg == '0)
        else $error("final pixel did not empty the run");

    a_pixel_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.final_pixel |=> run_reg != '0)
        else $error("accepted pixel not held");

    a_final_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_pixel |=> m_valid)
        else $error("final pixel produced no packet");

endmodule

`default_nettype wire
